[rtl/gsig_pkg.sv]
package gsig_pkg;

	// Defaults for the top level parameters
	localparam int EXP_TABLE_DEPTH_DEF = 4096;
	localparam int COORD_BITS_DEF      = 11;

	// Queue depths
	localparam int REQ_QUEUE_DEPTH = 4;
	localparam int RES_QUEUE_DEPTH = 16;

	// Register indexes (byte address = 4*index)
	localparam logic [2:0] REG_FRAME_WIDTH      = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT     = 3'd1;
	localparam logic [2:0] REG_SPOT_ONE_GAIN    = 3'd2;
	localparam logic [2:0] REG_SPOT_ONE_SPREAD  = 3'd3;
	localparam logic [2:0] REG_SPOT_FOUR_GAIN   = 3'd4;
	localparam logic [2:0] REG_SPOT_FOUR_SPREAD = 3'd5;

	// Register reset values
	localparam logic [11:0] FRAME_WIDTH_RST      = 12'd1024;
	localparam logic [11:0] FRAME_HEIGHT_RST     = 12'd512;
	localparam logic [15:0] SPOT_ONE_GAIN_RST    = 16'd16384;
	localparam logic [23:0] SPOT_ONE_SPREAD_RST  = 24'd131072;
	localparam logic [15:0] SPOT_FOUR_GAIN_RST   = 16'd8192;
	localparam logic [23:0] SPOT_FOUR_SPREAD_RST = 24'd131072;

	// Commands
	localparam logic CMD_PIXEL   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	// Spot motion
	localparam logic        DIR_RIGHT     = 1'b1;
	localparam logic [11:0] SPOT_ONE_RST  = 12'd50;
	localparam logic [11:0] SPOT_FOUR_RST = 12'd450;

	// Exp table in Q.30
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	typedef struct packed {
		logic        cmd;
		logic [10:0] pixel_x;
		logic [10:0] pixel_y;
		logic [7:0]  noise_sample;
	} request_t;

	typedef struct packed {
		logic [7:0]  pixel_value;
		logic [10:0] spot_one_x;
		logic [10:0] spot_four_x;
	} result_t;

	typedef struct packed {
		logic [11:0] frame_width;
		logic [11:0] frame_height;
		logic [15:0] spot_one_gain;
		logic [23:0] spot_one_spread;
		logic [15:0] spot_four_gain;
		logic [23:0] spot_four_spread;
	} cfg_t;

	// Step ratio exp(-s) in Q.30, Taylor sum through the s^8 term
	function automatic logic [63:0] exp_ratio(input logic [63:0] s);
		logic [63:0] term;
		logic [63:0] r;
		term = 64'(ONE_Q30);
		r    = 64'(ONE_Q30);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * s) >> 30) / 64'(k);
			if (k % 2 == 1) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		return r;
	endfunction

endpackage

[rtl/gaussian_spot_image_generator_top.sv]
// Channel   Direction  Handshake            Payload
// request   in         push / full          gsig_pkg::request_t
// result    out        pop / empty          gsig_pkg::result_t
// config    in/out     psel/penable/pready  6 registers at 4*index, 32-bit data
//
// After reset the exp table is filled, one entry per cycle, while full
// stays high; config writes are taken during that time.
// Then one request per clock is accepted while full is low; a result
// passes the request queue and the eight back-end pipeline stages before
// it enters the result queue, from which it can be popped.
// The back end issues only against free result-queue slots, so a stalled
// pop fills both queues and then raises full; nothing is dropped.
module gaussian_spot_image_generator_top #(
	parameter int EXP_TABLE_DEPTH = gsig_pkg::EXP_TABLE_DEPTH_DEF,
	parameter int COORD_BITS      = gsig_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	input  gsig_pkg::request_t request,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output gsig_pkg::result_t  result
);

	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

	gsig_pkg::cfg_t     cfg;
	gsig_pkg::request_t item;
	logic               item_valid, item_pop, tab_ready, tab_we;
	logic [IDX_W-1:0]   tab_waddr, rd_addr_one, rd_addr_four;
	logic [30:0]        tab_wdata, rd_data_one, rd_data_four;

	gsig_front #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.push      (push),
		.request   (request),
		.full      (full),
		.cfg       (cfg),
		.tab_ready (tab_ready),
		.tab_we    (tab_we),
		.tab_waddr (tab_waddr),
		.tab_wdata (tab_wdata),
		.item_pop  (item_pop),
		.item      (item),
		.item_valid(item_valid)
	);

	gsig_ram #(
		.WIDTH(31),
		.DEPTH(EXP_TABLE_DEPTH)
	) u_exp_table (
		.clk    (clk),
		.we     (tab_we),
		.waddr  (tab_waddr),
		.wdata  (tab_wdata),
		.raddr_a(rd_addr_one),
		.raddr_b(rd_addr_four),
		.rdata_a(rd_data_one),
		.rdata_b(rd_data_four)
	);

	gsig_back #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
		.COORD_BITS     (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.tab_ready   (tab_ready),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop),
		.rd_addr_one (rd_addr_one),
		.rd_addr_four(rd_addr_four),
		.rd_data_one (rd_data_one),
		.rd_data_four(rd_data_four),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

[rtl/gsig_ram.sv]
module gsig_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[rtl/gsig_fifo.sv]
module gsig_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty,
	output logic [CW-1:0]    count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[rtl/gsig_front.sv]
module gsig_front #(
	parameter int EXP_TABLE_DEPTH = gsig_pkg::EXP_TABLE_DEPTH_DEF,
	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	// config port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// request side
	input  logic                push,
	input  gsig_pkg::request_t  request,
	output logic                full,
	// toward back end
	output gsig_pkg::cfg_t      cfg,
	output logic                tab_ready,
	output logic                tab_we,
	output logic [IDX_W-1:0]    tab_waddr,
	output logic [30:0]         tab_wdata,
	input  logic                item_pop,
	output gsig_pkg::request_t  item,
	output logic                item_valid
);

	localparam logic [63:0] STEP_S    = (64'd1 << 34) / EXP_TABLE_DEPTH;
	localparam logic [63:0] EXP_RATIO = gsig_pkg::exp_ratio(STEP_S);
	localparam logic [61:0] HALF_Q30  = 62'd1 << 29;

	gsig_pkg::cfg_t   cfg_q;
	logic             wr_hit;
	logic [2:0]       reg_idx;
	logic [IDX_W-1:0] fill_idx_q;
	logic [30:0]      fill_val_q;
	logic             fill_done_q;
	logic [61:0]      fill_prod;
	logic [61:0]      fill_rnd;
	logic             q_full;
	logic             q_empty;
	logic [$clog2(gsig_pkg::REQ_QUEUE_DEPTH + 1)-1:0] q_count;

	assign pready  = 1'b1;
	assign wr_hit  = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width      <= gsig_pkg::FRAME_WIDTH_RST;
			cfg_q.frame_height     <= gsig_pkg::FRAME_HEIGHT_RST;
			cfg_q.spot_one_gain    <= gsig_pkg::SPOT_ONE_GAIN_RST;
			cfg_q.spot_one_spread  <= gsig_pkg::SPOT_ONE_SPREAD_RST;
			cfg_q.spot_four_gain   <= gsig_pkg::SPOT_FOUR_GAIN_RST;
			cfg_q.spot_four_spread <= gsig_pkg::SPOT_FOUR_SPREAD_RST;
		end else if (wr_hit) begin
			unique case (reg_idx)
				gsig_pkg::REG_FRAME_WIDTH:      cfg_q.frame_width      <= pwdata[11:0];
				gsig_pkg::REG_FRAME_HEIGHT:     cfg_q.frame_height     <= pwdata[11:0];
				gsig_pkg::REG_SPOT_ONE_GAIN:    cfg_q.spot_one_gain    <= pwdata[15:0];
				gsig_pkg::REG_SPOT_ONE_SPREAD:  cfg_q.spot_one_spread  <= pwdata[23:0];
				gsig_pkg::REG_SPOT_FOUR_GAIN:   cfg_q.spot_four_gain   <= pwdata[15:0];
				gsig_pkg::REG_SPOT_FOUR_SPREAD: cfg_q.spot_four_spread <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			gsig_pkg::REG_FRAME_WIDTH:      prdata = 32'(cfg_q.frame_width);
			gsig_pkg::REG_FRAME_HEIGHT:     prdata = 32'(cfg_q.frame_height);
			gsig_pkg::REG_SPOT_ONE_GAIN:    prdata = 32'(cfg_q.spot_one_gain);
			gsig_pkg::REG_SPOT_ONE_SPREAD:  prdata = 32'(cfg_q.spot_one_spread);
			gsig_pkg::REG_SPOT_FOUR_GAIN:   prdata = 32'(cfg_q.spot_four_gain);
			gsig_pkg::REG_SPOT_FOUR_SPREAD: prdata = 32'(cfg_q.spot_four_spread);
			default:                        prdata = '0;
		endcase
	end

	// exp table fill: entry i = round(entry(i-1) * ratio)
	assign fill_prod = 62'(fill_val_q) * 62'(EXP_RATIO);
	assign fill_rnd  = fill_prod + HALF_Q30;
	assign tab_we    = !fill_done_q;
	assign tab_waddr = fill_idx_q;
	assign tab_wdata = fill_val_q;
	assign tab_ready = fill_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_idx_q  <= '0;
			fill_val_q  <= gsig_pkg::ONE_Q30;
			fill_done_q <= 1'b0;
		end else if (!fill_done_q) begin
			fill_idx_q <= fill_idx_q + 1'b1;
			fill_val_q <= fill_rnd[60:30];
			if (fill_idx_q == IDX_W'(EXP_TABLE_DEPTH - 1)) begin
				fill_done_q <= 1'b1;
			end
		end
	end

	// request queue, closed until the table is filled
	assign full       = q_full || !fill_done_q;
	assign item_valid = !q_empty;

	gsig_fifo #(
		.WIDTH($bits(gsig_pkg::request_t)),
		.DEPTH(gsig_pkg::REQ_QUEUE_DEPTH)
	) u_req_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push && !full),
		.wr_data(request),
		.rd_en  (item_pop),
		.rd_data(item),
		.full   (q_full),
		.empty  (q_empty),
		.count  (q_count)
	);

`ifndef ASSERT_OFF
	// nothing enters the queue during the table fill
	a_no_push_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_done_q |=> (q_count == '0))
		else $error("request queued during table fill");
	// fill completes after exactly one pass
	a_fill_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fill_done_q) |-> (fill_idx_q == IDX_W'(EXP_TABLE_DEPTH)))
		else $error("table fill ended off the last entry");
	// queue count never exceeds depth
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($bits(q_count))'(gsig_pkg::REQ_QUEUE_DEPTH))
		else $error("request queue overflow");
`endif

endmodule

[rtl/gsig_back.sv]
module gsig_back #(
	parameter int EXP_TABLE_DEPTH = gsig_pkg::EXP_TABLE_DEPTH_DEF,
	parameter int COORD_BITS      = gsig_pkg::COORD_BITS_DEF,
	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gsig_pkg::cfg_t     cfg,
	input  logic               tab_ready,
	input  logic               item_valid,
	input  gsig_pkg::request_t item,
	output logic               item_pop,
	output logic [IDX_W-1:0]   rd_addr_one,
	output logic [IDX_W-1:0]   rd_addr_four,
	input  logic [30:0]        rd_data_one,
	input  logic [30:0]        rd_data_four,
	// result side
	output logic               empty,
	input  logic               pop,
	output gsig_pkg::result_t  result
);

	localparam int CW = $clog2(gsig_pkg::RES_QUEUE_DEPTH + 1);
	localparam logic [10:0] CMASK = (COORD_BITS >= 11) ? 11'h7FF
		: 11'((32'd1 << COORD_BITS) - 32'd1);
	localparam logic [44:0] ONE_Q44 = 45'd1 << 44;

	typedef struct packed {
		logic        pix;
		logic [7:0]  noise;
		logic [10:0] o1;
		logic [10:0] o4;
	} meta_t;

	function automatic logic [11:0] sat12(input logic signed [14:0] v);
		if (v < 15'sd0) begin
			return 12'd0;
		end else if (v > 15'sd4095) begin
			return 12'd4095;
		end
		return v[11:0];
	endfunction

	// spot state
	logic [11:0] pos1_q, pos4_q;
	logic        dir1_q, dir4_q;

	logic        issue, credit, is_adv;
	logic [CW-1:0] inflight_q;
	logic [CW-1:0] res_count;
	logic        res_full;

	logic signed [14:0] right, p1, p4, p1_pull;
	logic        d1n, d4n;
	logic [11:0] n1, n4;
	logic [10:0] px, py, cy;

	// pipeline
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	meta_t       m_s1, m_s2, m_s3, m_s4, m_s5, m_s6, m_s7;
	logic signed [12:0] dx1_s1, dx4_s1, dy_s1;
	logic [23:0] sqx1_s2, sqx4_s2, sqy_s2;
	logic [24:0] d2_1_s3, d2_4_s3;
	logic [48:0] a1_s4, a4_s4;
	logic        far1_s5, far4_s5;
	logic [46:0] t1_s6, t4_s6;
	logic [44:0] sum_s7;
	gsig_pkg::result_t res_s8;

	logic signed [25:0] sqx1, sqx4, sqy;
	logic [44:0] idx1_prod, idx4_prod;
	logic [47:0] sum_raw;
	logic [52:0] scaled;
	logic [8:0]  pix9;

	// issue when an item waits, the table is ready and a result-queue slot is free
	assign credit   = ((CW + 1)'(inflight_q) + (CW + 1)'(res_count))
		< (CW + 1)'(gsig_pkg::RES_QUEUE_DEPTH);
	assign issue    = item_valid && tab_ready && credit;
	assign item_pop = issue;
	assign is_adv   = (item.cmd == gsig_pkg::CMD_ADVANCE);

	// frame advance: move, bounce, keep spacing, saturate
	always_comb begin
		right = $signed({3'b0, cfg.frame_width}) - 15'sd50;
		p1    = $signed({3'b0, pos1_q}) + (dir1_q ? 15'sd11 : -15'sd11);
		p4    = $signed({3'b0, pos4_q}) + (dir4_q ? 15'sd10 : -15'sd10);
		d1n   = dir1_q ^ ((p1 <= 15'sd50) || (p1 >= right));
		d4n   = dir4_q ^ ((p4 <= 15'sd450) || (p4 >= right));
		if (d1n) begin
			p1_pull = ((p4 - 15'sd10) < p1) ? (p4 - 15'sd10) : p1;
		end else begin
			p1_pull = ((p4 + 15'sd10) > p1) ? (p4 + 15'sd10) : p1;
		end
		n1 = sat12(p1_pull);
		n4 = sat12(p4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos1_q <= gsig_pkg::SPOT_ONE_RST;
			pos4_q <= gsig_pkg::SPOT_FOUR_RST;
			dir1_q <= gsig_pkg::DIR_RIGHT;
			dir4_q <= gsig_pkg::DIR_RIGHT;
		end else if (issue && is_adv) begin
			pos1_q <= n1;
			pos4_q <= n4;
			dir1_q <= d1n;
			dir4_q <= d4n;
		end
	end

	assign px = item.pixel_x & CMASK;
	assign py = item.pixel_y & CMASK;
	assign cy = cfg.frame_height[11:1];

	// valid chain and in-flight count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
			inflight_q <= '0;
		end else begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8}
				<= {issue, vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7};
			if (issue && !vld_s8) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (vld_s8 && !issue) begin
				inflight_q <= inflight_q - 1'b1;
			end
		end
	end

	// s1: offsets from spot centers
	always_ff @(posedge clk) begin
		m_s1.pix   <= !is_adv;
		m_s1.noise <= item.noise_sample;
		m_s1.o1    <= (is_adv ? n1[10:0] : pos1_q[10:0]) & CMASK;
		m_s1.o4    <= (is_adv ? n4[10:0] : pos4_q[10:0]) & CMASK;
		dx1_s1     <= $signed({2'b0, px}) - $signed({1'b0, pos1_q});
		dx4_s1     <= $signed({2'b0, px}) - $signed({1'b0, pos4_q});
		dy_s1      <= $signed({2'b0, py}) - $signed({2'b0, cy});
	end

	// s2: squares
	assign sqx1 = dx1_s1 * dx1_s1;
	assign sqx4 = dx4_s1 * dx4_s1;
	assign sqy  = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		m_s2    <= m_s1;
		sqx1_s2 <= sqx1[23:0];
		sqx4_s2 <= sqx4[23:0];
		sqy_s2  <= sqy[23:0];
	end

	// s3: squared distance
	always_ff @(posedge clk) begin
		m_s3    <= m_s2;
		d2_1_s3 <= 25'(sqx1_s2) + 25'(sqy_s2);
		d2_4_s3 <= 25'(sqx4_s2) + 25'(sqy_s2);
	end

	// s4: exponent argument in Q.24
	always_ff @(posedge clk) begin
		m_s4  <= m_s3;
		a1_s4 <= 49'(d2_1_s3) * 49'(cfg.spot_one_spread);
		a4_s4 <= 49'(d2_4_s3) * 49'(cfg.spot_four_spread);
	end

	// s5: table lookup, far test
	assign idx1_prod    = 45'(a1_s4[27:0]) * 45'(EXP_TABLE_DEPTH);
	assign idx4_prod    = 45'(a4_s4[27:0]) * 45'(EXP_TABLE_DEPTH);
	assign rd_addr_one  = idx1_prod[28 +: IDX_W];
	assign rd_addr_four = idx4_prod[28 +: IDX_W];

	always_ff @(posedge clk) begin
		m_s5    <= m_s4;
		far1_s5 <= |a1_s4[48:28];
		far4_s5 <= |a4_s4[48:28];
	end

	// s6: gain times table value, Q.44
	always_ff @(posedge clk) begin
		m_s6  <= m_s5;
		t1_s6 <= far1_s5 ? '0 : 47'(cfg.spot_one_gain) * 47'(rd_data_one);
		t4_s6 <= far4_s5 ? '0 : 47'(cfg.spot_four_gain) * 47'(rd_data_four);
	end

	// s7: sum and clamp to one
	assign sum_raw = 48'(t1_s6) + 48'(t4_s6);

	always_ff @(posedge clk) begin
		m_s7   <= m_s6;
		sum_s7 <= (sum_raw > 48'(ONE_Q44)) ? ONE_Q44 : sum_raw[44:0];
	end

	// s8: scale to 255, add noise, saturate; zero pixel for an advance
	assign scaled = {sum_s7, 8'b0} - 53'(sum_s7);
	assign pix9   = 9'(scaled[51:44]) + 9'(m_s7.noise);

	always_ff @(posedge clk) begin
		res_s8.pixel_value <= !m_s7.pix ? 8'd0 : (pix9[8] ? 8'd255 : pix9[7:0]);
		res_s8.spot_one_x  <= m_s7.o1;
		res_s8.spot_four_x <= m_s7.o4;
	end

	gsig_fifo #(
		.WIDTH($bits(gsig_pkg::result_t)),
		.DEPTH(gsig_pkg::RES_QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (vld_s8),
		.wr_data(res_s8),
		.rd_en  (pop),
		.rd_data(result),
		.full   (res_full),
		.empty  (empty),
		.count  (res_count)
	);

`ifndef ASSERT_OFF
	// a finished result always finds room
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> !res_full)
		else $error("result queue overrun");
	// reserved slots never exceed the queue
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		((CW + 1)'(inflight_q) + (CW + 1)'(res_count))
			<= (CW + 1)'(gsig_pkg::RES_QUEUE_DEPTH))
		else $error("credit accounting broken");
	// spot state changes only on an issued advance
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(issue && is_adv) |=> ($stable(pos1_q) && $stable(pos4_q)))
		else $error("spot moved without advance");
	// no work before the table is complete
	a_tab_first: assert property (@(posedge clk) disable iff (!arst_n)
		!tab_ready |-> (inflight_q == '0))
		else $error("pixel in flight before table fill");
`endif

endmodule
